>>> rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants for the palette colour-cycling lookup
// Word layouts, range configuration record, register indexes and opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

package pcl_pkg;

   localparam int NumRangesDefault = 4;
   localparam int IdxW             = 8;
   localparam int ColorW           = 32;
   localparam int ShiftW           = 16;
   localparam int LenW             = IdxW + 1;
   localparam int CsrIndexW        = 3;
   localparam int CsrDataW         = 32;
   localparam int RangeCountW      = 3;
   localparam int PaletteDepth     = 1 << IdxW;

   localparam logic [ColorW-1:0] AlphaMask = 32'hFF00_0000;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_LOAD  = 1'b1
   } opcode_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_CYCLE_SHIFT       = 3'd0,
      CSR_ALPHA_FILL_ENABLE = 3'd1,
      CSR_FILL_ALPHA_COLOR  = 3'd2,
      CSR_RANGE_COUNT       = 3'd3,
      CSR_RANGE_LOW_BOUNDS  = 3'd4,
      CSR_RANGE_HIGH_BOUNDS = 3'd5
   } csr_index_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [IdxW-1:0]   pixel_index;
      logic [ColorW-1:0] entry_color;
      logic              last_in;
   } item_type;

   typedef struct packed {
      logic            enable;
      logic [IdxW-1:0] low;
      logic [IdxW-1:0] high;
      logic [LenW-1:0] length;
      logic [LenW-1:0] shift_mod;
   } range_cfg_type;

endpackage

`default_nettype wire

>>> rtl/pcl_req_if.sv
// ----------------------------------------------------------------------------
// pcl_req_if: request channel
// Valid/ready channel carrying pixel and palette-load words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcl_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [pcl_pkg::IdxW-1:0]    pixel_index;
   logic [pcl_pkg::ColorW-1:0]  entry_color;
   logic                        last_in;

   modport source (output valid, output opcode, output pixel_index,
                   output entry_color, output last_in, input ready);
   modport sink   (input valid, input opcode, input pixel_index,
                   input entry_color, input last_in, output ready);
endinterface

`default_nettype wire

>>> rtl/pcl_rsp_if.sv
// ----------------------------------------------------------------------------
// pcl_rsp_if: response channel
// Valid/ready channel carrying converted colour words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcl_pkg::ColorW-1:0]  color;
   logic                        last_out;

   modport source (output valid, output color, output last_out, input ready);
   modport sink   (input valid, input color, input last_out, output ready);
endinterface

`default_nettype wire

>>> rtl/pcl_shift_mod.sv
// ----------------------------------------------------------------------------
// pcl_shift_mod: shift modulo range length
// Restoring remainder, one shift bit per cycle, one lane per range.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_shift_mod #(
   parameter int NUM_RANGES = pcl_pkg::NumRangesDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pcl_pkg::ShiftW-1:0] shift,
   input  wire logic [pcl_pkg::LenW-1:0]   length [NUM_RANGES],
   output logic                            busy,
   output logic [pcl_pkg::LenW-1:0]        remainder [NUM_RANGES]
);

   localparam int CntW = $clog2(pcl_pkg::ShiftW);

   logic            busy_ff;
   logic [CntW-1:0] bit_cnt_ff;
   logic [pcl_pkg::LenW-1:0] rem_ff [NUM_RANGES];
   logic [pcl_pkg::LenW-1:0] rem_in [NUM_RANGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else if (start) begin
         busy_ff    <= 1'b1;
         bit_cnt_ff <= CntW'(pcl_pkg::ShiftW - 1);
      end else if (busy_ff) begin
         if (bit_cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
         bit_cnt_ff <= bit_cnt_ff - 1'b1;
      end
   end

   for (genvar r = 0; r < NUM_RANGES; r++) begin : g_lane
      logic [pcl_pkg::LenW:0] trial;

      always_comb begin
         trial = {rem_ff[r], shift[bit_cnt_ff]};
         if (trial >= {1'b0, length[r]}) begin
            rem_in[r] = pcl_pkg::LenW'(trial - {1'b0, length[r]});
         end else begin
            rem_in[r] = trial[pcl_pkg::LenW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            rem_ff[r] <= '0;
         end else if (busy_ff) begin
            rem_ff[r] <= rem_in[r];
         end
      end

      assign remainder[r] = rem_ff[r];
   end

   assign busy = busy_ff;

   a_start_loads : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && bit_cnt_ff == CntW'(pcl_pkg::ShiftW - 1))
      else $error("remainder unit did not start a full pass");

   a_pass_ends : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && bit_cnt_ff == '0 && !start) |=> !busy_ff)
      else $error("remainder unit ran past the last shift bit");

endmodule

`default_nettype wire

>>> rtl/pcl_csr.sv
// ----------------------------------------------------------------------------
// pcl_csr: configuration registers
// Register file plus per-range bounds, length and shift remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_csr #(
   parameter int NUM_RANGES = pcl_pkg::NumRangesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [pcl_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [pcl_pkg::CsrDataW-1:0]  csr_wdata,
   output logic                               busy,
   output logic                               fill_enable,
   output logic [pcl_pkg::ColorW-1:0]         fill_color,
   output pcl_pkg::range_cfg_type             range_cfg [NUM_RANGES]
);

   logic [pcl_pkg::ShiftW-1:0]      cycle_shift_ff;
   logic                            fill_enable_ff;
   logic [pcl_pkg::ColorW-1:0]      fill_color_ff;
   logic [pcl_pkg::RangeCountW-1:0] range_count_ff;
   logic [pcl_pkg::CsrDataW-1:0]    low_bounds_ff;
   logic [pcl_pkg::CsrDataW-1:0]    high_bounds_ff;
   logic                            start_ff;
   logic                            div_busy;
   logic [pcl_pkg::LenW-1:0]        length [NUM_RANGES];
   logic [pcl_pkg::LenW-1:0]        shift_mod [NUM_RANGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_shift_ff <= '0;
         fill_enable_ff <= 1'b0;
         fill_color_ff  <= '0;
         range_count_ff <= '0;
         low_bounds_ff  <= '0;
         high_bounds_ff <= '0;
         start_ff       <= 1'b0;
      end else begin
         start_ff <= csr_we;
         if (csr_we) begin
            unique case (pcl_pkg::csr_index_type'(csr_index))
               pcl_pkg::CSR_CYCLE_SHIFT: begin
                  cycle_shift_ff <= csr_wdata[pcl_pkg::ShiftW-1:0];
               end
               pcl_pkg::CSR_ALPHA_FILL_ENABLE: begin
                  fill_enable_ff <= csr_wdata[0];
               end
               pcl_pkg::CSR_FILL_ALPHA_COLOR: begin
                  fill_color_ff <= csr_wdata[pcl_pkg::ColorW-1:0];
               end
               pcl_pkg::CSR_RANGE_COUNT: begin
                  range_count_ff <= csr_wdata[pcl_pkg::RangeCountW-1:0];
               end
               pcl_pkg::CSR_RANGE_LOW_BOUNDS: begin
                  low_bounds_ff <= csr_wdata;
               end
               pcl_pkg::CSR_RANGE_HIGH_BOUNDS: begin
                  high_bounds_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   for (genvar r = 0; r < NUM_RANGES; r++) begin : g_range
      logic [pcl_pkg::IdxW-1:0] lo;
      logic [pcl_pkg::IdxW-1:0] hi;

      assign lo        = low_bounds_ff[r*pcl_pkg::IdxW +: pcl_pkg::IdxW];
      assign hi        = high_bounds_ff[r*pcl_pkg::IdxW +: pcl_pkg::IdxW];
      assign length[r] = {1'b0, hi} - {1'b0, lo} + pcl_pkg::LenW'(1);

      assign range_cfg[r].enable    = (cycle_shift_ff != '0)
                                    && (pcl_pkg::RangeCountW'(r) < range_count_ff)
                                    && (hi >= lo);
      assign range_cfg[r].low       = lo;
      assign range_cfg[r].high      = hi;
      assign range_cfg[r].length    = length[r];
      assign range_cfg[r].shift_mod = shift_mod[r];
   end

   pcl_shift_mod #(
      .NUM_RANGES (NUM_RANGES)
   ) u_shift_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .shift     (cycle_shift_ff),
      .length    (length),
      .busy      (div_busy),
      .remainder (shift_mod)
   );

   assign busy        = start_ff | div_busy;
   assign fill_enable = fill_enable_ff;
   assign fill_color  = fill_color_ff;

endmodule

`default_nettype wire

>>> rtl/pcl_cycle_stage.sv
// ----------------------------------------------------------------------------
// pcl_cycle_stage: one colour-cycling range
// Rotates an index inside its range back by the shift remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_cycle_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire pcl_pkg::item_type      in_item,
   input  wire pcl_pkg::range_cfg_type rcfg,
   output logic                        out_valid,
   output pcl_pkg::item_type           out_item
);

   logic                     valid_ff;
   pcl_pkg::item_type        item_ff;
   pcl_pkg::item_type        item_in;
   logic                     hit;
   logic [pcl_pkg::IdxW-1:0] offset;
   logic [pcl_pkg::LenW-1:0] moved;

   always_comb begin
      item_in = in_item;
      hit     = rcfg.enable && (in_item.opcode == pcl_pkg::OP_PIXEL)
              && (in_item.pixel_index >= rcfg.low)
              && (in_item.pixel_index <= rcfg.high);
      offset  = in_item.pixel_index - rcfg.low;
      if ({1'b0, offset} >= rcfg.shift_mod) begin
         moved = {1'b0, offset} - rcfg.shift_mod;
      end else begin
         moved = {1'b0, offset} + rcfg.length - rcfg.shift_mod;
      end
      if (hit) begin
         item_in.pixel_index = rcfg.low + moved[pcl_pkg::IdxW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

>>> rtl/pcl_palette.sv
// ----------------------------------------------------------------------------
// pcl_palette: palette memory and alpha fill
// Loads write the table in stream order; pixels read it, then fill applies.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_palette (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic                       in_valid,
   input  wire pcl_pkg::item_type          in_item,
   input  wire logic                       fill_enable,
   input  wire logic [pcl_pkg::ColorW-1:0] fill_color,
   output logic                            out_valid,
   output logic [pcl_pkg::ColorW-1:0]      out_color,
   output logic                            out_last
);

   logic [pcl_pkg::ColorW-1:0] palette_mem [pcl_pkg::PaletteDepth];
   logic [pcl_pkg::ColorW-1:0] rd_data_ff;
   logic                       m_valid_ff;
   pcl_pkg::opcode_type        m_opcode_ff;
   logic                       m_last_ff;
   logic                       out_valid_ff;
   logic [pcl_pkg::ColorW-1:0] out_color_ff;
   logic [pcl_pkg::ColorW-1:0] out_color_in;
   logic                       out_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_valid && in_item.opcode == pcl_pkg::OP_LOAD) begin
            palette_mem[in_item.pixel_index] <= in_item.entry_color;
         end
         rd_data_ff <= palette_mem[in_item.pixel_index];
      end
   end

   always_comb begin
      out_color_in = rd_data_ff;
      if (fill_enable && (rd_data_ff & pcl_pkg::AlphaMask) == '0) begin
         out_color_in = fill_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff   <= in_valid;
         out_valid_ff <= m_valid_ff && (m_opcode_ff == pcl_pkg::OP_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_opcode_ff  <= in_item.opcode;
         m_last_ff    <= in_item.last_in;
         out_color_ff <= out_color_in;
         out_last_ff  <= m_last_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_color = out_color_ff;
   assign out_last  = out_last_ff;

   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      (adv && m_valid_ff && m_opcode_ff == pcl_pkg::OP_LOAD) |=> !out_valid_ff)
      else $error("palette load word produced a response");

endmodule

`default_nettype wire

>>> rtl/palette_cycle_color_lookup.sv
// ----------------------------------------------------------------------------
// palette_cycle_color_lookup: 8-bit index to 32-bit colour with colour cycling
// Path: input register, per-range cycle stages, palette read and output registers.
// Throughput: one word per cycle; all stages advance together on a free
//   output register.
// After any csr write, requests are held off while the bit-serial
//   remainder unit recomputes shift mod length per range.
// Reset clears control and valid registers; palette entries stay unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_cycle_color_lookup #(
   parameter int NUM_RANGES = pcl_pkg::NumRangesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pcl_req_if.sink                            req_if,
   pcl_rsp_if.source                          rsp_if,
   input  wire logic                          csr_we,
   input  wire logic [pcl_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [pcl_pkg::CsrDataW-1:0]  csr_wdata
);

   logic                       adv;
   logic                       cfg_busy;
   logic                       fill_enable;
   logic [pcl_pkg::ColorW-1:0] fill_color;
   pcl_pkg::range_cfg_type     range_cfg [NUM_RANGES];
   logic                       accept;
   logic                       s0_valid_ff;
   pcl_pkg::item_type          s0_item_ff;
   logic                       st_valid [NUM_RANGES+1];
   pcl_pkg::item_type          st_item  [NUM_RANGES+1];

   pcl_csr #(
      .NUM_RANGES (NUM_RANGES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .busy        (cfg_busy),
      .fill_enable (fill_enable),
      .fill_color  (fill_color),
      .range_cfg   (range_cfg)
   );

   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv && !cfg_busy && !csr_we;
   assign accept       = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_item_ff.opcode      <= pcl_pkg::opcode_type'(req_if.opcode);
         s0_item_ff.pixel_index <= req_if.pixel_index;
         s0_item_ff.entry_color <= req_if.entry_color;
         s0_item_ff.last_in     <= req_if.last_in;
      end
   end

   assign st_valid[0] = s0_valid_ff;
   assign st_item[0]  = s0_item_ff;

   for (genvar r = 0; r < NUM_RANGES; r++) begin : g_cycle
      pcl_cycle_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (st_valid[r]),
         .in_item   (st_item[r]),
         .rcfg      (range_cfg[r]),
         .out_valid (st_valid[r+1]),
         .out_item  (st_item[r+1])
      );
   end

   pcl_palette u_palette (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (st_valid[NUM_RANGES]),
      .in_item     (st_item[NUM_RANGES]),
      .fill_enable (fill_enable),
      .fill_color  (fill_color),
      .out_valid   (rsp_if.valid),
      .out_color   (rsp_if.color),
      .out_last    (rsp_if.last_out)
   );

   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (cfg_busy || csr_we) |-> !accept)
      else $error("request word taken while shift remainders were stale");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for palette_cycle_color_lookup
// A short table of directed words and register writes is walked first, then
// six random segments, each under its own register setting. A local copy of
// the palette and registers predicts colour words the table leaves open.
// Guard loads keep pixels off unwritten entries. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import pcl_pkg::*;

   localparam int LatencyCycles = NumRangesDefault + 3;
   localparam int DrainCycles   = LatencyCycles + 3;
   localparam int StallLimit    = 4000;
   localparam int WordsPerSeg   = 80;

   localparam logic [CsrIndexW-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CsrIndexW-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [ColorW-1:0] color;
      logic              last_out;
   } result_type;

   typedef struct {
      logic              is_reg;
      csr_index_type     reg_index;
      logic [CsrDataW-1:0] reg_value;
      item_type          word;
      logic              typed;
      logic [ColorW-1:0] typed_color;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;

   pcl_req_if req_if ();
   pcl_rsp_if rsp_if ();

   palette_cycle_color_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the block's registers and palette
   logic [ShiftW-1:0]      shift_cfg;
   logic                   fill_on;
   logic [ColorW-1:0]      fill_color;
   logic [RangeCountW-1:0] ranges_in_use;
   logic [31:0]            low_bounds;
   logic [31:0]            high_bounds;
   logic [ColorW-1:0]      palette_copy [PaletteDepth];
   bit                     palette_written [PaletteDepth];

   result_type   expected_colors [$];
   step_row_type directed_rows [$];
   int           mismatch_count = 0;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           quiet_cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [IdxW-1:0] cycled_index(logic [IdxW-1:0] idx);
      int n;
      int lo;
      int hi;
      int span;
      int s;
      int i;
      i = int'(idx);
      if (shift_cfg == '0) return idx;
      n = (int'(ranges_in_use) > NumRangesDefault) ? NumRangesDefault : int'(ranges_in_use);
      for (int r = 0; r < n; r++) begin
         lo = int'(low_bounds[8*r +: 8]);
         hi = int'(high_bounds[8*r +: 8]);
         if (hi >= lo && i >= lo && i <= hi) begin
            span = hi - lo + 1;
            s    = int'(shift_cfg) % span;
            i    = lo + ((span + (i - lo) - s) % span);
         end
      end
      return IdxW'(i);
   endfunction

   function automatic logic [ColorW-1:0] lookup_color(logic [IdxW-1:0] idx);
      logic [ColorW-1:0] c;
      c = palette_copy[cycled_index(idx)];
      if (fill_on && (c & AlphaMask) == '0) c = fill_color;
      return c;
   endfunction

   function automatic void add_word(opcode_type op, logic [IdxW-1:0] idx,
                                    logic [ColorW-1:0] col, logic last,
                                    logic typed, logic [ColorW-1:0] typed_color);
      step_row_type row;
      row.is_reg      = 1'b0;
      row.reg_index   = CSR_CYCLE_SHIFT;
      row.reg_value   = '0;
      row.word        = '{opcode: op, pixel_index: idx, entry_color: col, last_in: last};
      row.typed       = typed;
      row.typed_color = typed_color;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
      step_row_type row;
      row.is_reg      = 1'b1;
      row.reg_index   = idx;
      row.reg_value   = value;
      row.word        = '0;
      row.typed       = 1'b0;
      row.typed_color = '0;
      directed_rows.push_back(row);
   endfunction

   task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   task automatic send_word(item_type w, logic typed, logic [ColorW-1:0] typed_color);
      result_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= w.opcode;
      req_if.pixel_index <= w.pixel_index;
      req_if.entry_color <= w.entry_color;
      req_if.last_in     <= w.last_in;
      do @(posedge clock); while (!req_if.ready);
      if (w.opcode == OP_LOAD) begin
         palette_copy[w.pixel_index]    = w.entry_color;
         palette_written[w.pixel_index] = 1'b1;
      end else begin
         want.color    = typed ? typed_color : lookup_color(w.pixel_index);
         want.last_out = w.last_in;
         expected_colors.push_back(want);
      end
   endtask

   // block idle: no word in flight, no colour word outstanding
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_CYCLE_SHIFT:       shift_cfg     = value[ShiftW-1:0];
         CSR_ALPHA_FILL_ENABLE: fill_on       = value[0];
         CSR_FILL_ALPHA_COLOR:  fill_color    = value[ColorW-1:0];
         CSR_RANGE_COUNT:       ranges_in_use = value[RangeCountW-1:0];
         CSR_RANGE_LOW_BOUNDS:  low_bounds    = value;
         CSR_RANGE_HIGH_BOUNDS: high_bounds   = value;
         default: ;
      endcase
   endtask

   task automatic program_setting(int seg);
      logic [ShiftW-1:0]      shift;
      logic [RangeCountW-1:0] count;
      logic                   fill;
      logic [ColorW-1:0]      fcol;
      logic [31:0]            lows;
      logic [31:0]            highs;
      int                     lo;
      int                     hi;
      case (seg)
         0: begin
            shift = '0;
            count = RangeCountW'($urandom_range(0, 7));
            fill  = 1'b0;
            fcol  = $urandom;
         end
         1: begin
            shift = '1;
            count = 3'd7;
            fill  = 1'b1;
            fcol  = '0;
         end
         2: begin
            shift = 16'd1;
            count = 3'd4;
            fill  = 1'b1;
            fcol  = '1;
         end
         3: begin
            shift = ShiftW'($urandom_range(1, 65535));
            count = '0;
            fill  = 1'b0;
            fcol  = $urandom;
         end
         default: begin
            shift = ($urandom_range(0, 1) == 0) ? ShiftW'($urandom_range(1, 600))
                                                 : ShiftW'($urandom_range(1, 65535));
            count = RangeCountW'($urandom_range(1, 7));
            fill  = 1'($urandom_range(0, 1));
            fcol  = $urandom;
         end
      endcase
      for (int r = 0; r < 4; r++) begin
         case ($urandom_range(0, 7))
            0: begin
               lo = 0;
               hi = 255;
            end
            1: begin
               lo = $urandom_range(1, 255);
               hi = $urandom_range(0, lo - 1);
            end
            2: begin
               lo = $urandom_range(0, 255);
               hi = lo;
            end
            default: begin
               lo = $urandom_range(0, 255);
               hi = lo + $urandom_range(0, (255 - lo < 40) ? 255 - lo : 40);
            end
         endcase
         lows[8*r +: 8]  = 8'(lo);
         highs[8*r +: 8] = 8'(hi);
      end
      settle();
      write_reg(CSR_RANGE_LOW_BOUNDS, lows);
      write_reg(CSR_RANGE_HIGH_BOUNDS, highs);
      write_reg(CSR_RANGE_COUNT, CsrDataW'(count));
      write_reg(CSR_FILL_ALPHA_COLOR, fcol);
      if (seg == 3 || seg == 4) begin
         write_reg(CSR_SPARE_6, $urandom);
         write_reg(CSR_SPARE_7, $urandom);
      end
      write_reg(CSR_ALPHA_FILL_ENABLE, CsrDataW'(fill));
      write_reg(CSR_CYCLE_SHIFT, CsrDataW'(shift));
      csr_we <= 1'b0;
   endtask

   // receiver stalls and result checking
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_colors.size() == 0) begin
            note_mismatch("unexpected colour word", 'x, rsp_if.color);
         end else begin
            want = expected_colors.pop_front();
            if (rsp_if.color !== want.color)
               note_mismatch("color", want.color, rsp_if.color);
            if (rsp_if.last_out !== want.last_out)
               note_mismatch("last_out", 32'(want.last_out), 32'(rsp_if.last_out));
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      item_type          w;
      logic [IdxW-1:0]   idx;
      logic [IdxW-1:0]   entry;
      logic [ColorW-1:0] col;
      logic              writing;
      int                r;
      int                lo;
      int                hi;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.opcode      = OP_PIXEL;
      req_if.pixel_index = '0;
      req_if.entry_color = '0;
      req_if.last_in     = 1'b0;
      rsp_if.ready       = 1'b0;
      quiet_cycles       = 0;
      shift_cfg          = '0;
      fill_on            = 1'b0;
      fill_color         = '0;
      ranges_in_use      = '0;
      low_bounds         = '0;
      high_bounds        = '0;
      send_idle_pct      = 16;
      recv_stall_pct     = 65;

      // after reset: cycling off, no fill; then fill, then ranges incl. an
      // inverted one and a count above the number of ranges
      add_word(OP_LOAD,  8'h00, 32'hFF00_0001, 1'b1, 1'b0, '0);
      add_word(OP_LOAD,  8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
      add_word(OP_LOAD,  8'h01, 32'h0000_0000, 1'b1, 1'b0, '0);
      add_word(OP_LOAD,  8'h02, 32'h80AB_CDEF, 1'b0, 1'b0, '0);
      add_word(OP_LOAD,  8'h03, 32'h7F00_0003, 1'b0, 1'b0, '0);
      add_word(OP_LOAD,  8'h10, 32'h00FF_00FF, 1'b1, 1'b0, '0);
      add_word(OP_PIXEL, 8'h00, 32'h0000_0000, 1'b0, 1'b1, 32'hFF00_0001);
      add_word(OP_PIXEL, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      add_word(OP_PIXEL, 8'h01, 32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000);
      add_reg(CSR_ALPHA_FILL_ENABLE, 32'd1);
      add_reg(CSR_FILL_ALPHA_COLOR, 32'hDEAD_BEEF);
      add_word(OP_PIXEL, 8'h01, 32'h0000_0000, 1'b1, 1'b1, 32'hDEAD_BEEF);
      add_word(OP_PIXEL, 8'h02, 32'h0000_0000, 1'b0, 1'b1, 32'h80AB_CDEF);
      add_reg(CSR_RANGE_LOW_BOUNDS, 32'hFFFF_1000);
      add_reg(CSR_RANGE_HIGH_BOUNDS, 32'hFFFF_0503);
      add_reg(CSR_RANGE_COUNT, 32'd7);
      add_reg(CSR_CYCLE_SHIFT, 32'd1);
      add_word(OP_PIXEL, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0);
      add_word(OP_PIXEL, 8'h03, 32'h0000_0000, 1'b1, 1'b0, '0);
      add_word(OP_PIXEL, 8'h10, 32'h0000_0000, 1'b0, 1'b0, '0);
      add_reg(CSR_CYCLE_SHIFT, 32'h0000_FFFF);
      add_word(OP_PIXEL, 8'h01, 32'h0000_0000, 1'b0, 1'b0, '0);
      add_word(OP_PIXEL, 8'hFF, 32'h0000_0000, 1'b1, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_reg) begin
            if (!writing) settle();
            write_reg(directed_rows[k].reg_index, directed_rows[k].reg_value);
            writing = 1'b1;
         end else begin
            if (writing) csr_we <= 1'b0;
            writing = 1'b0;
            send_word(directed_rows[k].word, directed_rows[k].typed,
                      directed_rows[k].typed_color);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 16;
               recv_stall_pct = 65;
            end
            1: begin
               send_idle_pct  = 65;
               recv_stall_pct = 16;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int s = 0; s < 2; s++) begin
            program_setting(2 * phase + s);
            for (int n = 0; n < WordsPerSeg; n++) begin
               col = $urandom;
               if ($urandom_range(0, 3) == 0) col[31:24] = 8'h00;
               if ($urandom_range(0, 3) == 0) begin
                  w = '{opcode: OP_LOAD, pixel_index: IdxW'($urandom_range(0, 255)),
                        entry_color: col, last_in: 1'($urandom_range(0, 1))};
                  send_word(w, 1'b0, '0);
               end else begin
                  r  = $urandom_range(0, 3);
                  lo = int'(low_bounds[8*r +: 8]);
                  hi = int'(high_bounds[8*r +: 8]);
                  if ($urandom_range(0, 3) != 0 && hi >= lo)
                     idx = IdxW'($urandom_range(lo, hi));
                  else
                     idx = IdxW'($urandom_range(0, 255));
                  entry = cycled_index(idx);
                  if (!palette_written[entry]) begin
                     w = '{opcode: OP_LOAD, pixel_index: entry, entry_color: col,
                           last_in: 1'($urandom_range(0, 1))};
                     send_word(w, 1'b0, '0);
                  end
                  w = '{opcode: OP_PIXEL, pixel_index: idx, entry_color: $urandom,
                        last_in: 1'($urandom_range(0, 1))};
                  send_word(w, 1'b0, '0);
               end
            end
         end
      end

      req_if.valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

>>> palette_cycle_color_lookup.f
rtl/pcl_pkg.sv
rtl/pcl_req_if.sv
rtl/pcl_rsp_if.sv
rtl/pcl_shift_mod.sv
rtl/pcl_csr.sv
rtl/pcl_cycle_stage.sv
rtl/pcl_palette.sv
rtl/palette_cycle_color_lookup.sv
verif/tb.sv
